FILE: design/lfc_pkg.sv
// Types, constants and the state table of the line follower controller.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package lfc_pkg;

  localparam int unsigned SPEED_W   = 14;
  localparam int unsigned STATE_W   = 4;
  localparam int unsigned DWELL_W   = 7;
  localparam int unsigned LAMP_W    = 4;
  localparam int unsigned REFL_W    = 8;
  localparam int unsigned BTN_W     = 2;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [STATE_W-1:0] NUM_STATES = 4'd11;
  localparam logic [STATE_W-1:0] ST_CENTER  = 4'd0;
  localparam logic [SPEED_W-1:0] MAX_SPEED  = 14'd16383;
  localparam int unsigned        SENSOR_LO  = 3;

  localparam logic [SPEED_W-1:0] RST_SPEED_INITIAL = 14'd2000;
  localparam logic [SPEED_W-1:0] RST_SPEED_STEP    = 14'd500;
  localparam logic [SPEED_W-1:0] RST_SPEED_LIMIT   = 14'd5000;
  localparam logic [SPEED_W-1:0] RST_STOPPED_DUTY  = 14'd10;
  localparam logic [DWELL_W-1:0] RST_DWELL         = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_INITIAL = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPPED_DUTY  = 4'd3;

  localparam int unsigned WHEEL_RIGHT = 0;
  localparam int unsigned WHEEL_LEFT  = 1;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_initial;
    logic [SPEED_W-1:0] speed_step;
    logic [SPEED_W-1:0] speed_limit;
    logic [SPEED_W-1:0] stopped_duty;
  } lfc_cfg_t;

  typedef struct packed {
    logic [1:0]              wheels;
    logic [DWELL_W-1:0]      dwell;
    logic [LAMP_W-1:0]       lamps;
    logic [3:0][STATE_W-1:0] next;
  } lfc_row_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left_drive;
    logic [SPEED_W-1:0] right_drive;
    logic [STATE_W-1:0] state_index;
    logic [LAMP_W-1:0]  lamp_mask;
    logic               stepped;
  } lfc_result_t;

  // The next-state list is written highest sensor code first.
  function automatic lfc_row_t lfc_row(input logic [STATE_W-1:0] s);
    lfc_row_t r;
    case (s)
      4'd1:    r = '{2'b10, 7'd50,  4'h1, {4'd2, 4'd6, 4'd2, 4'd3}};
      4'd2:    r = '{2'b11, 7'd50,  4'h0, {4'd0, 4'd7, 4'd1, 4'd1}};
      4'd3:    r = '{2'b10, 7'd100, 4'h1, {4'd2, 4'd6, 4'd2, 4'd4}};
      4'd4:    r = '{2'b11, 7'd50,  4'h0, {4'd2, 4'd2, 4'd2, 4'd3}};
      4'd5:    r = '{2'b00, 7'd25,  4'hC, {4'd2, 4'd2, 4'd2, 4'd5}};
      4'd6:    r = '{2'b01, 7'd50,  4'h8, {4'd7, 4'd7, 4'd1, 4'd8}};
      4'd7:    r = '{2'b11, 7'd50,  4'h0, {4'd0, 4'd6, 4'd2, 4'd6}};
      4'd8:    r = '{2'b01, 7'd100, 4'h8, {4'd7, 4'd7, 4'd1, 4'd9}};
      4'd9:    r = '{2'b11, 7'd50,  4'h0, {4'd7, 4'd7, 4'd7, 4'd8}};
      4'd10:   r = '{2'b00, 7'd25,  4'hC, {4'd7, 4'd7, 4'd7, 4'd10}};
      default: r = '{2'b11, 7'd100, 4'h3, {4'd0, 4'd6, 4'd1, 4'd8}};
    endcase
    return r;
  endfunction

endpackage

FILE: design/lfc_in_if.sv
// Input channel of the line follower controller: one sensor word per tick.
// Depends on lfc_pkg.
`timescale 1ns / 1ps

interface lfc_in_if
  import lfc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [REFL_W-1:0] reflect_bits;
  logic [BTN_W-1:0]  buttons;

  modport source (output valid, output reflect_bits, output buttons, input ready);
  modport sink   (input valid, input reflect_bits, input buttons, output ready);
endinterface

FILE: design/lfc_out_if.sv
// Result channel of the line follower controller: one drive word per tick.
// Depends on lfc_pkg.
`timescale 1ns / 1ps

interface lfc_out_if
  import lfc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] left_drive;
  logic [SPEED_W-1:0] right_drive;
  logic [STATE_W-1:0] state_index;
  logic [LAMP_W-1:0]  lamp_mask;
  logic               stepped;

  modport source (output valid, output left_drive, output right_drive,
                  output state_index, output lamp_mask, output stepped, input ready);
  modport sink   (input valid, input left_drive, input right_drive,
                  input state_index, input lamp_mask, input stepped, output ready);
endinterface

FILE: design/lfc_cfg_if.sv
// Configuration write channel of the line follower controller.
// Depends on lfc_pkg.
`timescale 1ns / 1ps

interface lfc_cfg_if
  import lfc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SPEED_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/lfc_cfg_regs.sv
// Configuration register file of the line follower controller.
// Depends on lfc_pkg and lfc_cfg_if.
`timescale 1ns / 1ps

module lfc_cfg_regs
  import lfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lfc_cfg_if.sink    cfg_ch,
  output lfc_cfg_t   cfg
);

  lfc_cfg_t cfg_r;
  lfc_cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SPEED_INITIAL: cfg_nxt.speed_initial = cfg_ch.data;
        CFG_SPEED_STEP:    cfg_nxt.speed_step    = cfg_ch.data;
        CFG_SPEED_LIMIT:   cfg_nxt.speed_limit   = cfg_ch.data;
        CFG_STOPPED_DUTY:  cfg_nxt.stopped_duty  = cfg_ch.data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_initial <= RST_SPEED_INITIAL;
      cfg_r.speed_step    <= RST_SPEED_STEP;
      cfg_r.speed_limit   <= RST_SPEED_LIMIT;
      cfg_r.stopped_duty  <= RST_STOPPED_DUTY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: design/lfc_speed_unit.sv
// Button speed update for one wheel: saturating step, or wrap to the initial speed.
// Depends on lfc_pkg.
`timescale 1ns / 1ps

module lfc_speed_unit
  import lfc_pkg::*;
(
  input  logic [SPEED_W-1:0] speed,
  input  logic               press,
  input  lfc_cfg_t           cfg,
  output logic [SPEED_W-1:0] speed_nxt
);

  logic [SPEED_W:0] sum;

  assign sum = {1'b0, speed} + {1'b0, cfg.speed_step};

  always_comb begin
    if (!press) begin
      speed_nxt = speed;
    end else if (speed < cfg.speed_limit) begin
      speed_nxt = (sum > {1'b0, MAX_SPEED}) ? MAX_SPEED : sum[SPEED_W-1:0];
    end else begin
      speed_nxt = cfg.speed_initial;
    end
  end

endmodule

FILE: design/lfc_fsm_core.sv
// State, dwell counter, wheel speeds and button history of the line follower.
// Depends on lfc_pkg and lfc_speed_unit.
`timescale 1ns / 1ps

module lfc_fsm_core
  import lfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [REFL_W-1:0] reflect_bits,
  input  logic [BTN_W-1:0]  buttons,
  input  lfc_cfg_t          cfg,
  output lfc_result_t       result
);

  logic [STATE_W-1:0] state_r, state_nxt;
  logic [DWELL_W-1:0] dwell_r, dwell_nxt;
  logic [SPEED_W-1:0] left_speed_r, left_speed_nxt;
  logic [SPEED_W-1:0] right_speed_r, right_speed_nxt;
  logic [BTN_W-1:0]   last_buttons_r, last_buttons_nxt;

  logic [STATE_W-1:0] cur;
  lfc_row_t           row;
  lfc_row_t           next_row;
  logic               last_tick;
  logic [1:0]         sel;
  logic [STATE_W-1:0] next_state;
  logic [BTN_W-1:0]   rising;
  logic [SPEED_W-1:0] left_bumped, right_bumped;

  assign cur        = (state_r < NUM_STATES) ? state_r : ST_CENTER;
  assign row        = lfc_row(cur);
  assign last_tick  = (dwell_r <= 7'd1);
  assign sel        = reflect_bits[SENSOR_LO +: 2];
  assign next_state = row.next[sel];
  assign next_row   = lfc_row(next_state);
  assign rising     = buttons & ~last_buttons_r;

  lfc_speed_unit u_left_speed (
    .speed     (left_speed_r),
    .press     (rising[WHEEL_LEFT]),
    .cfg       (cfg),
    .speed_nxt (left_bumped)
  );

  lfc_speed_unit u_right_speed (
    .speed     (right_speed_r),
    .press     (rising[WHEEL_RIGHT]),
    .cfg       (cfg),
    .speed_nxt (right_bumped)
  );

  always_comb begin
    result.left_drive  = row.wheels[WHEEL_LEFT]  ? left_speed_r  : cfg.stopped_duty;
    result.right_drive = row.wheels[WHEEL_RIGHT] ? right_speed_r : cfg.stopped_duty;
    result.state_index = cur;
    result.lamp_mask   = row.lamps;
    result.stepped     = last_tick;
  end

  always_comb begin
    state_nxt        = state_r;
    dwell_nxt        = dwell_r;
    left_speed_nxt   = left_speed_r;
    right_speed_nxt  = right_speed_r;
    last_buttons_nxt = last_buttons_r;
    if (advance) begin
      if (last_tick) begin
        state_nxt        = next_state;
        dwell_nxt        = next_row.dwell;
        left_speed_nxt   = left_bumped;
        right_speed_nxt  = right_bumped;
        last_buttons_nxt = buttons;
      end else begin
        state_nxt = cur;
        dwell_nxt = dwell_r - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CENTER;
      dwell_r        <= RST_DWELL;
      left_speed_r   <= RST_SPEED_INITIAL;
      right_speed_r  <= RST_SPEED_INITIAL;
      last_buttons_r <= '0;
    end else begin
      state_r        <= state_nxt;
      dwell_r        <= dwell_nxt;
      left_speed_r   <= left_speed_nxt;
      right_speed_r  <= right_speed_nxt;
      last_buttons_r <= last_buttons_nxt;
    end
  end

endmodule

FILE: design/line_follower_fsm_controller.sv
// Top level of the line follower controller: configuration, state core and result register.
// Depends on lfc_pkg, the three channel interfaces, lfc_cfg_regs and lfc_fsm_core.
//
// The in_ch channel takes one word per 1 ms tick: the eight reflectance bits and the
// two speed buttons. For every accepted word the out_ch channel gives exactly one word:
// both motor drives, the state index and lamp mask held before the tick, and a flag
// that marks a tick on which the dwell ended and a transition was taken.
// The result is registered and appears in the cycle after the word is accepted. A new word
// can be accepted in every cycle while the receiver is ready, so the sustained rate is one
// word per cycle; it is set by the single result register, which holds a finished word while the next one is taken in.
// When the receiver stalls, the result register holds its word and in_ch.ready drops
// until that word is taken; no state changes while a word is refused.
// cfg_ch writes the four speed registers by index, is always ready and ignores an index
// beyond the last register. The user must make writes only while idle; nothing checks this.
// After reset the block is in the centre state with 100 ticks of dwell, both wheel
// speeds at 2000, the registers at their default values and no result pending.
`timescale 1ns / 1ps

module line_follower_fsm_controller
  import lfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lfc_in_if.sink    in_ch,
  lfc_out_if.source out_ch,
  lfc_cfg_if.sink   cfg_ch
);

  lfc_cfg_t    cfg;
  lfc_result_t result;
  lfc_result_t result_r;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  lfc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  lfc_fsm_core u_fsm_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (accept),
    .reflect_bits (in_ch.reflect_bits),
    .buttons      (in_ch.buttons),
    .cfg          (cfg),
    .result       (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_drive  = result_r.left_drive;
  assign out_ch.right_drive = result_r.right_drive;
  assign out_ch.state_index = result_r.state_index;
  assign out_ch.lamp_mask   = result_r.lamp_mask;
  assign out_ch.stepped     = result_r.stepped;

endmodule
